>>> rtl/core/trtt_pkg.sv
// ----------------------------------------------------------------------------
// trtt_pkg: shared types and constants for the trigger rule table
// request and result structs, opcode, comparator and status codes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trtt_pkg;

  localparam int MAX_RULES     = 12;
  localparam int PENDING_DEPTH = 8;
  localparam int VALUE_W       = 32;

  localparam int OPCODE_W  = 3;
  localparam int RULE_ID_W = 4;
  localparam int CMP_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 32;
  localparam int FILL_W    = 4;

  localparam int SLOT_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int PTR_W  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD   = 3'd0,
    OP_DEL   = 3'd1,
    OP_CLEAR = 3'd2,
    OP_EVAL  = 3'd3,
    OP_POP   = 3'd4
  } opcode_t;

  typedef enum logic [CMP_W-1:0] {
    CMP_GT = 3'd0,
    CMP_LT = 3'd1,
    CMP_GE = 3'd2,
    CMP_LE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_CMP   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NO_RULE   = 3'd3,
    ST_PEND_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [RULE_ID_W-1:0]      rule_index;
    logic [CMP_W-1:0]          comparator;
    logic signed [VALUE_W-1:0] threshold;
    logic                      level_mode;
    logic signed [VALUE_W-1:0] sample_value;
    logic                      read_ok;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic                 fired;
    logic [RULE_ID_W-1:0] rule_id;
    logic [COUNT_W-1:0]   fire_count;
    logic [FILL_W-1:0]    pending_count;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/core/threshold_rule_trigger_table.sv
// ----------------------------------------------------------------------------
// threshold_rule_trigger_table: trigger rule table with pending id queue
// holds up to twelve compare rules; add, delete, clear, evaluate and pop
// requests each give one result, with fired ids queued in an 8-entry fifo
// ----------------------------------------------------------------------------
// A request is taken at any clock edge where start is high; busy is never
// raised, so one request per cycle is sustained. Each request gives exactly
// one result. In the cycle after it is taken, the request register feeds the
// rule lookup, compare and table update logic. The result register captures
// the answer at the next edge. out_valid is then high for a single cycle with
// out_res. The receiver cannot stall, so it must take every result in the
// cycle it appears. Back-to-back requests see each other's table and queue
// updates, because the single read-modify-write of the slot registers and
// fifo pointers completes at the edge that ends the lookup cycle.
`timescale 1ns / 1ps
`default_nettype none

module threshold_rule_trigger_table
  import trtt_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  start,
  output logic busy,
  input  req_t in_req,
  output logic out_valid,
  output res_t out_res
);

  // request register
  logic req_valid_r;
  req_t req_r;

  // rule table
  logic [MAX_RULES-1:0]      slot_active_r;
  logic [CMP_W-1:0]          slot_cmp_r      [MAX_RULES];
  logic signed [VALUE_W-1:0] slot_thr_r      [MAX_RULES];
  logic                      slot_level_r    [MAX_RULES];
  logic                      slot_was_true_r [MAX_RULES];
  logic [COUNT_W-1:0]        slot_fires_r    [MAX_RULES];

  // pending fifo
  logic [SLOT_W-1:0] pend_ids_r [PENDING_DEPTH];
  logic [PTR_W-1:0]  pend_head_r, pend_head_nxt;
  logic [FILL_W-1:0] pend_fill_r, pend_fill_nxt;

  // result register
  logic out_valid_r;
  res_t out_res_r, out_res_nxt;

  // update controls from the compute cycle
  logic              add_we, del_we, clr_all, eval_we, fire_we, push_we;
  logic [SLOT_W-1:0] free_idx, sel_idx;
  logic              cond_now;
  logic [COUNT_W-1:0] fires_inc;
  logic [PTR_W-1:0]  pend_tail;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= start && !busy;
    end
    req_r <= in_req;
  end

  assign sel_idx   = req_r.rule_index[SLOT_W-1:0];
  assign pend_tail = pend_head_r + pend_fill_r[PTR_W-1:0];
  assign fires_inc = slot_fires_r[sel_idx] + COUNT_W'(1);

  always_comb begin
    logic free_found;
    logic sel_ok;
    logic fire;
    free_found    = 1'b0;
    free_idx      = '0;
    sel_ok        = 1'b0;
    fire          = 1'b0;
    cond_now      = 1'b0;
    add_we        = 1'b0;
    del_we        = 1'b0;
    clr_all       = 1'b0;
    eval_we       = 1'b0;
    fire_we       = 1'b0;
    push_we       = 1'b0;
    pend_head_nxt = pend_head_r;
    pend_fill_nxt = pend_fill_r;
    out_res_nxt   = '0;
    out_res_nxt.status = ST_OK;

    // lowest free slot
    for (int i = MAX_RULES - 1; i >= 0; i--) begin
      if (!slot_active_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end

    // index in range and slot in use
    if ({1'b0, req_r.rule_index} < (RULE_ID_W + 1)'(MAX_RULES)) begin
      sel_ok = slot_active_r[sel_idx];
    end

    // comparator of the selected rule against the sample
    case (slot_cmp_r[sel_idx])
      CMP_GT:  cond_now = req_r.sample_value >  slot_thr_r[sel_idx];
      CMP_LT:  cond_now = req_r.sample_value <  slot_thr_r[sel_idx];
      CMP_GE:  cond_now = req_r.sample_value >= slot_thr_r[sel_idx];
      CMP_LE:  cond_now = req_r.sample_value <= slot_thr_r[sel_idx];
      CMP_EQ:  cond_now = req_r.sample_value == slot_thr_r[sel_idx];
      CMP_NE:  cond_now = req_r.sample_value != slot_thr_r[sel_idx];
      default: cond_now = 1'b0;
    endcase

    if (req_valid_r) begin
      case (req_r.opcode)
        OP_ADD: begin
          // invalid comparator is checked before a full table
          if (req_r.comparator > CMP_NE) begin
            out_res_nxt.status = ST_BAD_CMP;
          end else if (!free_found) begin
            out_res_nxt.status = ST_FULL;
          end else begin
            add_we = 1'b1;
            out_res_nxt.rule_id = RULE_ID_W'(free_idx);
          end
        end
        OP_DEL: begin
          if (!sel_ok) begin
            out_res_nxt.status = ST_NO_RULE;
          end else begin
            del_we = 1'b1;
          end
        end
        OP_CLEAR: begin
          clr_all = 1'b1;
        end
        OP_EVAL: begin
          if (!sel_ok) begin
            out_res_nxt.status = ST_NO_RULE;
          end else if (!req_r.read_ok) begin
            // failed read keeps edge state and reports the current count
            out_res_nxt.fire_count = slot_fires_r[sel_idx];
          end else begin
            eval_we = 1'b1;
            fire = slot_level_r[sel_idx] ? cond_now
                                         : (cond_now && !slot_was_true_r[sel_idx]);
            if (fire) begin
              fire_we = 1'b1;
              out_res_nxt.fired      = 1'b1;
              out_res_nxt.fire_count = fires_inc;
              // id is dropped when the queue is full
              if (pend_fill_r < FILL_W'(PENDING_DEPTH)) begin
                push_we       = 1'b1;
                pend_fill_nxt = pend_fill_r + FILL_W'(1);
              end
            end else begin
              out_res_nxt.fire_count = slot_fires_r[sel_idx];
            end
          end
        end
        OP_POP: begin
          if (pend_fill_r == '0) begin
            out_res_nxt.status = ST_PEND_EMPTY;
          end else begin
            out_res_nxt.rule_id = RULE_ID_W'(pend_ids_r[pend_head_r]);
            pend_head_nxt = pend_head_r + PTR_W'(1);
            pend_fill_nxt = pend_fill_r - FILL_W'(1);
          end
        end
        default: begin
          // unused opcodes report ok and change nothing
        end
      endcase
    end

    out_res_nxt.pending_count = pend_fill_nxt;
  end

  // control state of the table and fifo
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_active_r <= '0;
      pend_head_r   <= '0;
      pend_fill_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (clr_all) begin
        slot_active_r <= '0;
      end
      if (add_we) begin
        slot_active_r[free_idx] <= 1'b1;
      end
      if (del_we) begin
        slot_active_r[sel_idx] <= 1'b0;
      end
      pend_head_r <= pend_head_nxt;
      pend_fill_r <= pend_fill_nxt;
      out_valid_r <= req_valid_r;
    end
  end

  // rule payload and queued ids, written before they are read
  always_ff @(posedge clk) begin
    if (add_we) begin
      slot_cmp_r[free_idx]      <= req_r.comparator;
      slot_thr_r[free_idx]      <= req_r.threshold;
      slot_level_r[free_idx]    <= req_r.level_mode;
      slot_was_true_r[free_idx] <= 1'b0;
      slot_fires_r[free_idx]    <= '0;
    end
    if (eval_we) begin
      slot_was_true_r[sel_idx] <= cond_now;
    end
    if (fire_we) begin
      slot_fires_r[sel_idx] <= fires_inc;
    end
    if (push_we) begin
      pend_ids_r[pend_tail] <= sel_idx;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire
